/* rtl/dti_pkg.sv */
// Shared constants, codes and structs for the decision tree inference block.
`timescale 1ns / 1ps
package dti_pkg;

   // Table sizes and walk limit.
   localparam int NODES       = 256;
   localparam int FEATURES    = 32;
   localparam int DEPTH_LIMIT = 16;

   // Field widths fixed by the interface.
   localparam int OPCODE_W   = 2;
   localparam int NODE_IDX_W = 8;
   localparam int FEAT_IDX_W = 5;
   localparam int VALUE_W    = 32;
   localparam int SCORE_W    = 17;
   localparam int LINK_W     = 9;
   localparam int STATUS_W   = 2;
   localparam int LEVEL_W    = (DEPTH_LIMIT > 1) ? $clog2(DEPTH_LIMIT) : 1;

   localparam logic [SCORE_W-1:0] SCORE_HALF = SCORE_W'(32768);
   localparam logic [SCORE_W-1:0] SCORE_ONE  = SCORE_W'(65536);

   // Opcodes carried in the request tuser.
   localparam logic [OPCODE_W-1:0] OP_NODE_WR  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_FEAT_WR  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_CLASSIFY = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_LEAF     = 2'd0,
      ST_MISSING  = 2'd1,
      ST_NO_TREE  = 2'd2,
      ST_DEPTH    = 2'd3
   } dti_status_type;

   typedef struct packed {
      logic                         is_leaf;
      logic [FEAT_IDX_W-1:0]        feature;
      logic signed [VALUE_W-1:0]    threshold;
   } dti_split_type;

   typedef struct packed {
      logic [SCORE_W-1:0] leaf_score;
      logic [LINK_W-1:0]  left;
      logic [LINK_W-1:0]  right;
   } dti_links_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic           node_we;
      logic           feat_we;
      logic           walk_start;
      logic           walk_step;
      logic           result_load;
      dti_status_type result_status;
   } dti_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic tree_valid;
      logic is_leaf;
      logic missing;
   } dti_stat_type;

endpackage

/* rtl/dti_datapath.sv */
// Datapath: node tables, feature registers, split compare and result register.
`timescale 1ns / 1ps
module dti_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  dti_pkg::dti_cmd_type               cmd,
   output dti_pkg::dti_stat_type              stat,
   input  logic                               csr_we,
   input  logic                               csr_wdata,
   input  logic [dti_pkg::NODE_IDX_W-1:0]     node_index,
   input  dti_pkg::dti_split_type             node_split_wr,
   input  dti_pkg::dti_links_type             node_links_wr,
   input  logic [dti_pkg::FEAT_IDX_W-1:0]     feature_index,
   input  logic [dti_pkg::VALUE_W-1:0]        feature_value,
   output logic [dti_pkg::SCORE_W-1:0]        score,
   output logic [dti_pkg::STATUS_W-1:0]       status
);
   import dti_pkg::*;

   dti_split_type               split_mem [NODES];
   dti_links_type               links_mem [NODES];
   logic signed [VALUE_W-1:0]   feat_ff [FEATURES];

   logic                        tree_valid_ff;
   logic [NODE_IDX_W-1:0]       cur_ff;
   logic [NODE_IDX_W-1:0]       cur_in;
   dti_split_type               split_rd_ff;
   dti_links_type               links_rd_ff;
   logic [SCORE_W-1:0]          score_ff;
   logic [SCORE_W-1:0]          score_in;
   logic [STATUS_W-1:0]         status_ff;

   logic signed [VALUE_W-1:0]   fv;
   logic [LINK_W-1:0]           next_link;
   logic [SCORE_W-1:0]          leaf_clamped;

   always_ff @(posedge clock) begin
      if (reset) begin
         tree_valid_ff <= 1'b0;
      end else if (csr_we) begin
         tree_valid_ff <= csr_wdata;
      end
   end

   // The read address follows the next node, so the registered read data
   // always belongs to the node held in cur_ff.
   always_comb begin
      cur_in = cur_ff;
      if (cmd.walk_start) begin
         cur_in = '0;
      end else if (cmd.walk_step) begin
         cur_in = next_link[NODE_IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.node_we) begin
         split_mem[node_index] <= node_split_wr;
         links_mem[node_index] <= node_links_wr;
      end
      split_rd_ff <= split_mem[cur_in];
      links_rd_ff <= links_mem[cur_in];
   end

   always_ff @(posedge clock) begin
      if (cmd.feat_we) begin
         feat_ff[feature_index] <= feature_value;
      end
   end

   assign fv           = feat_ff[split_rd_ff.feature];
   assign next_link    = (fv < split_rd_ff.threshold) ? links_rd_ff.left : links_rd_ff.right;
   assign leaf_clamped = (links_rd_ff.leaf_score > SCORE_ONE) ? SCORE_ONE
                                                              : links_rd_ff.leaf_score;

   assign stat.tree_valid = tree_valid_ff;
   assign stat.is_leaf    = split_rd_ff.is_leaf;
   assign stat.missing    = (next_link >= LINK_W'(NODES));

   assign score_in = (cmd.result_status == ST_LEAF) ? leaf_clamped : SCORE_HALF;

   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         score_ff  <= score_in;
         status_ff <= cmd.result_status;
      end
   end

   assign score  = score_ff;
   assign status = status_ff;

endmodule

/* rtl/dti_ctrl.sv */
// Controller: accepts request beats, sequences the tree walk, owns response valid.
`timescale 1ns / 1ps
module dti_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [dti_pkg::OPCODE_W-1:0]    opcode,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output dti_pkg::dti_cmd_type            cmd,
   input  dti_pkg::dti_stat_type           stat
);
   import dti_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_WALK
   } state_type;

   state_type            state_ff, state_in;
   logic [LEVEL_W-1:0]   level_ff, level_in;
   logic                 ready_ff, ready_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 accept;
   logic                 out_free;
   logic                 finished;
   dti_status_type       finish_code;

   assign accept   = req_tvalid && ready_ff;
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      finished    = 1'b1;
      finish_code = ST_LEAF;
      if (!stat.tree_valid) begin
         finish_code = ST_NO_TREE;
      end else if (stat.is_leaf) begin
         finish_code = ST_LEAF;
      end else if (stat.missing) begin
         finish_code = ST_MISSING;
      end else if (level_ff == LEVEL_W'(DEPTH_LIMIT - 1)) begin
         finish_code = ST_DEPTH;
      end else begin
         finished = 1'b0;
      end
   end

   always_comb begin
      state_in          = state_ff;
      level_in          = level_ff;
      cmd               = '0;
      cmd.result_status = finish_code;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (opcode)
                  OP_NODE_WR: cmd.node_we = 1'b1;
                  OP_FEAT_WR: cmd.feat_we = 1'b1;
                  OP_CLASSIFY: begin
                     cmd.walk_start = 1'b1;
                     level_in       = '0;
                     state_in       = S_WALK;
                  end
                  default: ;
               endcase
            end
         end
         S_WALK: begin
            if (finished) begin
               if (out_free) begin
                  cmd.result_load = 1'b1;
                  state_in        = S_IDLE;
               end
            end else begin
               cmd.walk_step = 1'b1;
               level_in      = level_ff + LEVEL_W'(1);
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign ready_in     = (state_in == S_IDLE);
   assign rsp_valid_in = cmd.result_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         level_ff     <= '0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = ready_ff;
   assign rsp_tvalid = rsp_valid_ff;

   // A result is only loaded into a free or draining output register.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.result_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over an untaken response");

   // A classify beat starts a walk on the next cycle.
   a_classify_walks: assert property (@(posedge clock) disable iff (reset)
      (accept && opcode == OP_CLASSIFY) |=> (state_ff == S_WALK && !ready_ff))
      else $error("classify beat did not start a walk");

   // Loading a result shows a response and frees the request side.
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.result_load |=> (rsp_valid_ff && ready_ff && state_ff == S_IDLE))
      else $error("loaded result not presented");

   // A walk step never runs past the depth limit.
   a_step_depth: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_step |-> (level_ff != LEVEL_W'(DEPTH_LIMIT - 1)))
      else $error("walk stepped past the depth limit");

endmodule

/* rtl/decision_tree_inference.sv */
// Top level of the decision tree inference block: port packing and submodule wiring.
`timescale 1ns / 1ps
// Usage:
// The request channel (req_*) carries one beat per operation, the opcode in
// req_tuser: write a node into the 256-entry node table, write one element of
// the 32-entry feature vector, or classify the loaded vector. Write beats are
// taken one per cycle while no classify walk is in flight, and produce no
// response. A classify beat produces one response beat (rsp_*) with the score
// in rsp_tdata and the status in rsp_tuser. The csr_we / csr_wdata port sets the
// tree-valid flag; the user must write it only while no classify is in flight;
// the block itself does not enforce this. Throughput: a classify walks one tree
// level per cycle, limited by the single registered read port of the node
// tables. req_tready rises in the same cycle as the response is presented. A
// classify with no tree loaded finishes at the root without walking.
// Reset clears the controller and the tree-valid flag; node and feature contents
// are undefined until written. When the receiver stalls, the response waits in
// the output register while new write beats are still taken; a later classify
// finishes its walk and holds until the output register frees.
module decision_tree_inference (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // node_index[7:0], node_is_leaf[8], node_feature[13:9], node_threshold[45:14],
   // leaf_score[62:46], node_left[71:63], node_right[80:72],
   // feature_index[85:81], feature_value[117:86], zero pad [119:118]
   input  logic [119:0]  req_tdata,
   // opcode[1:0]
   input  logic [1:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // score[16:0], zero pad [23:17]
   output logic [23:0]   rsp_tdata,
   // status[1:0]
   output logic [1:0]    rsp_tuser,
   input  logic          csr_we,
   input  logic          csr_wdata
);
   import dti_pkg::*;

   dti_cmd_type              cmd;
   dti_stat_type             stat;
   dti_split_type            split_wr;
   dti_links_type            links_wr;
   logic [SCORE_W-1:0]       score;
   logic [STATUS_W-1:0]      status;

   // Unpack a request beat into the node table entry formats.
   assign split_wr.is_leaf    = req_tdata[8];
   assign split_wr.feature    = req_tdata[13:9];
   assign split_wr.threshold  = req_tdata[45:14];
   assign links_wr.leaf_score = req_tdata[62:46];
   assign links_wr.left       = req_tdata[71:63];
   assign links_wr.right      = req_tdata[80:72];

   dti_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .opcode     (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   dti_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .node_index    (req_tdata[7:0]),
      .node_split_wr (split_wr),
      .node_links_wr (links_wr),
      .feature_index (req_tdata[85:81]),
      .feature_value (req_tdata[117:86]),
      .score         (score),
      .status        (status)
   );

   // Score sits in the low bits of the response, padded to whole bytes.
   assign rsp_tdata = {7'd0, score};
   assign rsp_tuser = status;

endmodule
